@@ rtl/jhcb_pkg.sv @@
// Shared constants, codes and types of the JPEG Huffman code table builder.
`timescale 1ns / 1ps

package jhcb_pkg;

  localparam int TABLE_ENTRIES   = 256;
  localparam int AC_SYMBOLS      = 162;
  localparam int DC_SYMBOLS      = 12;
  localparam int MAX_CODE_LENGTH = 16;
  localparam int NUM_LENGTHS     = 16;

  localparam int IDX_W  = $clog2(TABLE_ENTRIES);
  localparam int LEN_W  = 5;
  localparam int CODE_W = 16;
  localparam int NC_W   = CODE_W + 1;
  localparam int WORD_W = LEN_W + CODE_W;
  localparam int CL_W   = $clog2(NUM_LENGTHS) + 1;
  localparam int TS_W   = 9;

  localparam logic [TS_W-1:0] AC_TABLE_SIZE = TS_W'(TABLE_ENTRIES);
  localparam logic [TS_W-1:0] DC_TABLE_SIZE = TS_W'(DC_SYMBOLS);
  localparam logic [7:0]      AC_LIMIT      = 8'(AC_SYMBOLS);
  localparam logic [7:0]      DC_LIMIT      = 8'(DC_SYMBOLS);

  typedef enum logic [1:0] {
    CMD_START  = 2'd0,
    CMD_COUNT  = 2'd1,
    CMD_SYMBOL = 2'd2,
    CMD_READ   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_RDATA
  } state_t;

  typedef logic [WORD_W-1:0] entry_word_t;

endpackage

@@ rtl/jhcb_in_if.sv @@
// Input channel of the table builder: command and data byte with valid and ready.
`timescale 1ns / 1ps

interface jhcb_in_if
  import jhcb_pkg::*;
;
  logic       valid;
  logic       ready;
  cmd_t       cmd;
  logic [7:0] data_byte;

  modport source (output valid, output cmd, output data_byte, input ready);
  modport sink   (input valid, input cmd, input data_byte, output ready);
endinterface

@@ rtl/jhcb_out_if.sv @@
// Result channel of the table builder: one table entry report with valid and ready.
`timescale 1ns / 1ps

interface jhcb_out_if
  import jhcb_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [7:0]        entry_index;
  logic [LEN_W-1:0]  code_length;
  logic [CODE_W-1:0] code_word;
  logic              entry_valid;
  logic              error;

  modport source (output valid, output entry_index, output code_length,
                  output code_word, output entry_valid, output error, input ready);
  modport sink   (input valid, input entry_index, input code_length,
                  input code_word, input entry_valid, input error, output ready);
endinterface

@@ rtl/jhcb_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps

module jhcb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ rtl/jpeg_huffman_code_table_builder.sv @@
// Top level of the JPEG canonical Huffman code table builder.
// The builder turns a BITS list and a HUFFVAL symbol list into an encoder
// lookup table of code words and lengths, one entry per symbol.
// Items arrive on in_ch (cmd, data_byte) as valid/ready transactions: a start
// item clears the table, sixteen count items load the BITS list, each symbol
// item takes the next canonical code, and read items return a stored entry.
// Every item yields exactly one result transaction on out_ch.
// The cfg_wr_en/cfg_wr_data port writes ac_mode; change it only when idle.
// Flow: an item is taken in the idle state and finished in the exec state,
// and no new item is taken until it is finished. A symbol item steps over
// each empty code length in turn in the exec state (at most fifteen), and a
// read of a filled entry passes through the read-data state for the RAM read.
// The entries live in a 256 x 21 RAM; the per-entry used bits are flops that
// a start item clears all at once, so no clearing pass is needed.
// Reset empties the table state, selects the DC table and drops out valid.
// When the receiver stalls, the result waits in the output register; the
// next item may still be taken and is held until the register frees up.
`timescale 1ns / 1ps

module jpeg_huffman_code_table_builder
  import jhcb_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  jhcb_in_if.sink    in_ch,
  jhcb_out_if.source out_ch,
  input  logic       cfg_wr_en,
  input  logic       cfg_wr_data
);

  state_t state_r, state_nxt;

  // Accepted transaction.
  cmd_t       cmd_r;
  logic [7:0] data_r;

  logic ac_mode_r;

  // Build state.
  logic [7:0]        counts_r [NUM_LENGTHS];
  logic [CL_W-1:0]   loaded_r, loaded_nxt;
  logic [LEN_W-1:0]  cur_len_r, cur_len_nxt;
  logic [7:0]        left_r, left_nxt;
  logic [NC_W-1:0]   next_code_r, next_code_nxt;
  logic [7:0]        taken_r, taken_nxt;
  logic [TABLE_ENTRIES-1:0] used_r, used_nxt;

  // Output register.
  logic              out_valid_r, out_valid_nxt;
  logic [7:0]        out_idx_r, out_idx_nxt;
  logic [LEN_W-1:0]  out_len_r, out_len_nxt;
  logic [CODE_W-1:0] out_code_r, out_code_nxt;
  logic              out_ev_r, out_ev_nxt;
  logic              out_err_r, out_err_nxt;

  logic        in_acc;
  logic        out_free;
  logic [7:0]  sym_idx;
  logic [TS_W-1:0] tsize;
  logic [7:0]  sym_limit;
  logic        sym_rejected;
  logic        need_skip;
  logic        overflow;
  logic        read_in_range;
  logic        read_hit;
  logic        emit;
  logic        cnt_we;
  logic        rd_en;
  logic        wr_en;
  entry_word_t wr_word;
  entry_word_t rd_word;

  assign in_acc   = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;

  // In AC mode the table index is the symbol with its nibbles swapped.
  assign sym_idx   = ac_mode_r ? {data_r[3:0], data_r[7:4]} : data_r;
  assign tsize     = ac_mode_r ? AC_TABLE_SIZE : DC_TABLE_SIZE;
  assign sym_limit = ac_mode_r ? AC_LIMIT : DC_LIMIT;

  assign sym_rejected = (loaded_r < CL_W'(NUM_LENGTHS)) || (taken_r >= sym_limit) ||
                        ({1'b0, sym_idx} >= tsize);
  assign need_skip    = (left_r == 8'd0) && (cur_len_r < LEN_W'(NUM_LENGTHS));
  assign overflow     = (left_r == 8'd0) || (cur_len_r > LEN_W'(MAX_CODE_LENGTH)) ||
                        ((next_code_r >> cur_len_r) != '0);

  assign read_in_range = ({1'b0, data_r} < tsize);
  assign read_hit      = read_in_range && used_r[data_r[IDX_W-1:0]];

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (cmd_r == CMD_READ && read_hit) begin
          state_nxt = ST_RDATA;
        end else if (cmd_r == CMD_SYMBOL && !sym_rejected && need_skip) begin
          state_nxt = ST_EXEC;
        end else if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_RDATA: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Actions and next values of the build state and the output register.
  always_comb begin
    in_ch.ready   = (state_r == ST_IDLE);
    emit          = 1'b0;
    cnt_we        = 1'b0;
    rd_en         = 1'b0;
    wr_en         = 1'b0;
    wr_word       = {cur_len_r, next_code_r[CODE_W-1:0]};
    loaded_nxt    = loaded_r;
    cur_len_nxt   = cur_len_r;
    left_nxt      = left_r;
    next_code_nxt = next_code_r;
    taken_nxt     = taken_r;
    used_nxt      = used_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_idx_nxt   = out_idx_r;
    out_len_nxt   = out_len_r;
    out_code_nxt  = out_code_r;
    out_ev_nxt    = out_ev_r;
    out_err_nxt   = out_err_r;

    case (state_r)
      ST_EXEC: begin
        case (cmd_r)
          CMD_START: begin
            emit = out_free;
            if (emit) begin
              loaded_nxt    = '0;
              cur_len_nxt   = LEN_W'(1);
              left_nxt      = '0;
              next_code_nxt = '0;
              taken_nxt     = '0;
              used_nxt      = '0;
              out_idx_nxt   = '0;
              out_err_nxt   = 1'b0;
            end
          end
          CMD_COUNT: begin
            emit = out_free;
            if (emit) begin
              out_idx_nxt = '0;
              out_err_nxt = (loaded_r >= CL_W'(NUM_LENGTHS));
              if (loaded_r < CL_W'(NUM_LENGTHS)) begin
                cnt_we     = 1'b1;
                loaded_nxt = loaded_r + CL_W'(1);
                // The last count arms the walk at length one.
                if (loaded_r == CL_W'(NUM_LENGTHS - 1)) begin
                  cur_len_nxt   = LEN_W'(1);
                  next_code_nxt = '0;
                  left_nxt      = counts_r[0];
                end
              end
            end
          end
          CMD_SYMBOL: begin
            if (!sym_rejected && need_skip) begin
              // Step over one empty length: the code doubles.
              next_code_nxt = {next_code_r[NC_W-2:0], 1'b0};
              cur_len_nxt   = cur_len_r + LEN_W'(1);
              left_nxt      = counts_r[cur_len_r[CL_W-2:0]];
            end else begin
              emit = out_free;
              if (emit) begin
                out_idx_nxt = sym_idx;
                out_err_nxt = sym_rejected || overflow;
                if (!sym_rejected && !overflow) begin
                  wr_en         = 1'b1;
                  used_nxt[sym_idx[IDX_W-1:0]] = 1'b1;
                  next_code_nxt = next_code_r + NC_W'(1);
                  left_nxt      = left_r - 8'd1;
                  taken_nxt     = taken_r + 8'd1;
                end
              end
            end
          end
          CMD_READ: begin
            if (read_hit) begin
              rd_en = 1'b1;
            end else begin
              emit = out_free;
              if (emit) begin
                out_idx_nxt = data_r;
                out_err_nxt = !read_in_range;
              end
            end
          end
          default: ;
        endcase
        if (emit) begin
          out_valid_nxt = 1'b1;
          out_len_nxt   = wr_en ? cur_len_r : '0;
          out_code_nxt  = wr_en ? next_code_r[CODE_W-1:0] : '0;
          out_ev_nxt    = wr_en;
        end
      end
      ST_RDATA: begin
        emit = out_free;
        if (emit) begin
          out_valid_nxt = 1'b1;
          out_idx_nxt   = data_r;
          out_len_nxt   = rd_word[WORD_W-1:CODE_W];
          out_code_nxt  = rd_word[CODE_W-1:0];
          out_ev_nxt    = 1'b1;
          out_err_nxt   = 1'b0;
        end
      end
      default: ;
    endcase
  end

  // Entry store. A write and a later read of the same entry always fall
  // in different items, so the RAM needs no forwarding.
  jhcb_ram #(
    .WIDTH (WORD_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_entry_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (sym_idx[IDX_W-1:0]),
    .wr_data (wr_word),
    .rd_en   (rd_en),
    .rd_addr (data_r[IDX_W-1:0]),
    .rd_data (rd_word)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ac_mode_r   <= 1'b0;
      loaded_r    <= '0;
      cur_len_r   <= LEN_W'(1);
      left_r      <= '0;
      next_code_r <= '0;
      taken_r     <= '0;
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      loaded_r    <= loaded_nxt;
      cur_len_r   <= cur_len_nxt;
      left_r      <= left_nxt;
      next_code_r <= next_code_nxt;
      taken_r     <= taken_nxt;
      used_r      <= used_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        ac_mode_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      cmd_r  <= in_ch.cmd;
      data_r <= in_ch.data_byte;
    end
    if (cnt_we) begin
      counts_r[loaded_r[CL_W-2:0]] <= data_r;
    end
    out_idx_r  <= out_idx_nxt;
    out_len_r  <= out_len_nxt;
    out_code_r <= out_code_nxt;
    out_ev_r   <= out_ev_nxt;
    out_err_r  <= out_err_nxt;
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.entry_index = out_idx_r;
  assign out_ch.code_length = out_len_r;
  assign out_ch.code_word   = out_code_r;
  assign out_ch.entry_valid = out_ev_r;
  assign out_ch.error       = out_err_r;

  // A finished start leaves every entry empty.
  a_start_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EXEC && cmd_r == CMD_START && out_free) |=> (used_r == '0))
    else $error("start did not clear the used bits");

  // A result never carries both a code and an error.
  a_valid_no_error: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> !(out_ch.entry_valid && out_ch.error))
    else $error("result has a code and an error");

  // A returned code has a length from one to the maximum.
  a_code_length: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.entry_valid) |->
      (out_ch.code_length != '0 && out_ch.code_length <= LEN_W'(MAX_CODE_LENGTH)))
    else $error("returned code length out of range");

  // The count pointer never passes the number of lengths.
  a_loaded_bound: assert property (@(posedge clk) disable iff (!rst_n)
    loaded_r <= CL_W'(NUM_LENGTHS))
    else $error("count pointer overran");

  // The read-data state is only entered after a RAM read was issued.
  a_rdata_follows_read: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(state_r == ST_RDATA) |-> $past(rd_en))
    else $error("read data awaited without a RAM read");

endmodule
